>>> hdl/ppts_pkg.sv
`default_nettype none
package ppts_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned SLOT_W  = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] remaining;
    logic [FIELD_W-1:0] original;
    logic [FIELD_W-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

>>> hdl/ppts_table.sv
`default_nettype none
module ppts_table #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  we_i,
  input  wire         [$clog2(DEPTH)-1:0]      waddr_i,
  input  ppts_pkg::entry_t                     wdata_i,
  input  wire         [$clog2(DEPTH)-1:0]      raddr_i,
  output ppts_pkg::entry_t                     rdata_o
);
  import ppts_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/preemptive_priority_tick_scheduler_unit.sv
`default_nettype none
// Preemptive priority tick scheduler. The process table sits in one synchronous memory with a
// single write port and one registered read port. A load, clear or unknown op goes straight
// to the response state. A tick scans the N loaded entries one per cycle through the read
// port and then updates the chosen entry, if any. When the served entry completes, its
// turnaround time is found in the update, its wait time in ST_WT and the running totals in
// ST_SUM before the response. One item is worked on at a time; the next item is taken as
// soon as the result has moved into the output register, even while that result still
// waits to be taken downstream.
module preemptive_priority_tick_scheduler_unit #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_axis_tvalid,
  output logic          s_axis_tready,
  // arrival_time[15:0], burst_time[31:16], priority_req[47:32]
  input  wire  [47:0]   s_axis_tdata,
  // op[1:0]
  input  wire  [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  wire           m_axis_tready,
  // slot[3:0], idle[4], finished[5], wait_ticks[29:6], turnaround_time[53:30],
  // total_wait[81:54], total_turnaround[109:82], time_now[133:110], all_done[134],
  // table_full[135]
  output logic [135:0]  m_axis_tdata
);
  import ppts_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_PROCESSES);
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCESSES);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_WT   = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_RESP = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   loaded_q, loaded_d;
  logic [CNT_W-1:0]   done_q, done_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [SUM_W-1:0]   wsum_q, wsum_d;
  logic [SUM_W-1:0]   tsum_q, tsum_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic               cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  entry_t             best_q, best_d;
  logic               out_valid_q, out_valid_d;
  logic [135:0]       out_data_q, out_data_d;

  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic               res_idle_q, res_idle_d;
  logic               res_fin_q, res_fin_d;
  logic               res_full_q, res_full_d;
  logic [TIME_W-1:0]  res_wt_q, res_wt_d;
  logic [TIME_W-1:0]  res_tat_q, res_tat_d;

  logic               in_xfer;
  op_e                op;
  entry_t             load_entry;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             mem_rdata;
  logic               eligible;
  logic [TIME_W-1:0]  time_inc;
  logic [SUM_W:0]     wsum_add;
  logic [SUM_W:0]     tsum_add;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign load_entry    = '{arrival:   s_axis_tdata[15:0],
                           remaining: s_axis_tdata[31:16],
                           original:  s_axis_tdata[31:16],
                           prio:      s_axis_tdata[47:32]};

  assign eligible = cmp_v_q
                 && (TIME_W'(mem_rdata.arrival) <= time_q)
                 && (mem_rdata.remaining != '0)
                 && (!found_q || (mem_rdata.prio < best_q.prio));

  assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
  assign wsum_add = {1'b0, wsum_q} + (SUM_W + 1)'(res_wt_q);
  assign tsum_add = {1'b0, tsum_q} + (SUM_W + 1)'(res_tat_q);

  ppts_table #(
    .DEPTH (MAX_PROCESSES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    done_d      = done_q;
    time_d      = time_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    iss_d       = iss_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_slot_d  = res_slot_q;
    res_idle_d  = res_idle_q;
    res_fin_d   = res_fin_q;
    res_full_d  = res_full_q;
    res_wt_d    = res_wt_q;
    res_tat_d   = res_tat_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = loaded_q[IDX_W-1:0];
    mem_wdata   = load_entry;
    mem_raddr   = iss_q[IDX_W-1:0];

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (eligible) begin
      found_d    = 1'b1;
      best_idx_d = cmp_idx_q;
      best_d     = mem_rdata;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_slot_d = '0;
          res_idle_d = 1'b0;
          res_fin_d  = 1'b0;
          res_full_d = 1'b0;
          res_wt_d   = '0;
          res_tat_d  = '0;
          state_d    = ST_RESP;
          case (op)
            OP_LOAD: begin
              if (loaded_q == CNT_FULL) begin
                res_full_d = 1'b1;
              end else begin
                mem_we     = 1'b1;
                loaded_d   = loaded_q + CNT_W'(1);
                res_slot_d = SLOT_W'(loaded_q[IDX_W-1:0]);
                if (load_entry.remaining == '0) begin
                  done_d = done_q + CNT_W'(1);
                end
              end
            end
            OP_TICK: begin
              iss_d   = '0;
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            OP_CLEAR: begin
              loaded_d = '0;
              done_d   = '0;
              time_d   = '0;
              wsum_d   = '0;
              tsum_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_q == loaded_q) begin
          state_d = ST_UPD;
        end else begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = iss_q[IDX_W-1:0];
          iss_d     = iss_q + CNT_W'(1);
        end
      end
      ST_UPD: begin
        time_d  = time_inc;
        state_d = ST_RESP;
        if (!found_q) begin
          res_idle_d = 1'b1;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = best_idx_q;
          mem_wdata        = best_q;
          mem_wdata.remaining = best_q.remaining - FIELD_W'(1);
          res_slot_d       = SLOT_W'(best_idx_q);
          if (best_q.remaining == FIELD_W'(1)) begin
            res_fin_d = 1'b1;
            done_d    = done_q + CNT_W'(1);
            res_tat_d = time_inc - TIME_W'(best_q.arrival);
            state_d   = ST_WT;
          end
        end
      end
      ST_WT: begin
        res_wt_d = (res_tat_q >= TIME_W'(best_q.original))
                 ? res_tat_q - TIME_W'(best_q.original) : '0;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        wsum_d  = wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
        tsum_d  = tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_full_q, (done_q == loaded_q), time_q, tsum_q, wsum_q,
                         res_tat_q, res_wt_q, res_fin_q, res_idle_q, res_slot_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      done_q      <= '0;
      time_q      <= '0;
      wsum_q      <= '0;
      tsum_q      <= '0;
      iss_q       <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      done_q      <= done_d;
      time_q      <= time_d;
      wsum_q      <= wsum_d;
      tsum_q      <= tsum_d;
      iss_q       <= iss_d;
      cmp_v_q     <= cmp_v_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_slot_q <= res_slot_d;
    res_idle_q <= res_idle_d;
    res_fin_q  <= res_fin_d;
    res_full_q <= res_full_d;
    res_wt_q   <= res_wt_d;
    res_tat_q  <= res_tat_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_done_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("completed count exceeds loaded count");

  a_loaded_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CNT_FULL)
    else $error("loaded count exceeds table depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= loaded_q))
    else $error("scan ran past the loaded entries");

  a_idle_not_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]))
    else $error("idle tick reported a completion");
`endif

endmodule
`default_nettype wire
